/* design/affine2d_matrix_accumulator_assert.svh */
// Assertion macros used by the affine accumulator sequencer.
`ifndef AFFINE2D_MATRIX_ACCUMULATOR_ASSERT_SVH
`define AFFINE2D_MATRIX_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked at every rising clk edge outside reset.
`define AFF2D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AFF2D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/aff2d_pkg.sv */
// Types, constants and helper functions of the affine matrix accumulator.
package aff2d_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int WIDE_BITS = 2 * WORD_BITS + 2;
  localparam int EPS_BITS  = 17;
  localparam int NUM_ELEM  = 6;
  localparam int IDX_BITS  = $clog2(NUM_ELEM);

  localparam logic [EPS_BITS-1:0] EPS_RESET = EPS_BITS'(7);
  localparam logic signed [WORD_BITS-1:0] ONE_Q = WORD_BITS'(1) << FRAC_BITS;
  localparam logic signed [WIDE_BITS-1:0] ROUND_Q = WIDE_BITS'(1) << (FRAC_BITS - 1);
  localparam logic signed [WIDE_BITS-1:0] WMAX = (WIDE_BITS'(1) << (WORD_BITS - 1)) - 1;
  localparam logic signed [WIDE_BITS-1:0] WMIN = -WMAX - 1;

  // command codes
  localparam logic [3:0] CMD_LOAD  = 4'd0;
  localparam logic [3:0] CMD_IDENT = 4'd1;
  localparam logic [3:0] CMD_ZERO  = 4'd2;
  localparam logic [3:0] CMD_ADD   = 4'd3;
  localparam logic [3:0] CMD_SUB   = 4'd4;
  localparam logic [3:0] CMD_SCALE = 4'd5;
  localparam logic [3:0] CMD_ADDSC = 4'd6;
  localparam logic [3:0] CMD_MUL   = 4'd7;
  localparam logic [3:0] CMD_INV   = 4'd8;

  typedef struct packed {
    logic [3:0]                  cmd;
    logic signed [WORD_BITS-1:0] in_e00;
    logic signed [WORD_BITS-1:0] in_e01;
    logic signed [WORD_BITS-1:0] in_e10;
    logic signed [WORD_BITS-1:0] in_e11;
    logic signed [WORD_BITS-1:0] in_e20;
    logic signed [WORD_BITS-1:0] in_e21;
    logic signed [WORD_BITS-1:0] scale;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_e00;
    logic signed [WORD_BITS-1:0] res_e01;
    logic signed [WORD_BITS-1:0] res_e10;
    logic signed [WORD_BITS-1:0] res_e11;
    logic signed [WORD_BITS-1:0] res_e20;
    logic signed [WORD_BITS-1:0] res_e21;
    logic signed [WORD_BITS-1:0] determinant;
    logic                        singular;
    logic                        overflow;
  } out_word_t;

  // multiplier operand sources
  typedef enum logic [2:0] {SRC_ACC, SRC_NEW, SRC_IN, SRC_SCALE, SRC_ONE} src_t;

  // what the finished sum of products is written to
  typedef enum logic [2:0] {WB_NONE, WB_ELEM, WB_DET, WB_IDET, WB_T0, WB_T1} wb_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_MUL, ST_ACC, ST_FIN, ST_CHK,
    ST_DLOAD, ST_DRUN, ST_DDONE, ST_COMMIT, ST_OUT
  } state_t;

  typedef struct packed {
    src_t                asrc;
    logic [IDX_BITS-1:0] aidx;
    src_t                bsrc;
    logic [IDX_BITS-1:0] bidx;
    logic                neg;
    logic                last;
  } term_t;

  typedef struct packed {
    logic                latch;
    logic                simple;
    logic                mul;
    logic                acc_init;
    logic                acc_rnd;
    logic                acc_add;
    wb_t                 wb;
    logic [IDX_BITS-1:0] elem;
    term_t               term;
    logic                sing_copy;
    logic                div_load;
    logic                div_step;
    logic                div_done;
    logic                commit;
  } ctl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       sing;
  } sts_t;

  // clamp to the signed word range
  function automatic logic signed [WORD_BITS-1:0] sat_word(
      input logic signed [WIDE_BITS-1:0] v);
    logic signed [WORD_BITS-1:0] r;
    if (v > WMAX) r = WMAX[WORD_BITS-1:0];
    else if (v < WMIN) r = WMIN[WORD_BITS-1:0];
    else r = v[WORD_BITS-1:0];
    return r;
  endfunction

  function automatic logic ovf_word(input logic signed [WIDE_BITS-1:0] v);
    return (v > WMAX) || (v < WMIN);
  endfunction

endpackage

/* design/aff2d_ctrl.sv */
// Sequencer of the affine accumulator: steps the multiply, accumulate and divide passes.
`include "affine2d_matrix_accumulator_assert.svh"
module aff2d_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  output logic              dst_valid,
  input  logic              dst_stall,
  input  aff2d_pkg::sts_t   sts,
  output aff2d_pkg::ctl_t   ctl
);

  localparam int CNT_BITS = $clog2(aff2d_pkg::WORD_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(aff2d_pkg::WORD_BITS - 1);
  localparam logic [aff2d_pkg::IDX_BITS-1:0] ELEM_LAST =
      aff2d_pkg::IDX_BITS'(aff2d_pkg::NUM_ELEM - 1);

  aff2d_pkg::state_t state, state_next;
  aff2d_pkg::wb_t    job, job_next;
  logic [aff2d_pkg::IDX_BITS-1:0] elem, elem_next;
  logic [1:0]        term, term_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  aff2d_pkg::term_t  op;

  function automatic aff2d_pkg::term_t mk(
      input aff2d_pkg::src_t as, input int ai, input aff2d_pkg::src_t bs,
      input int bi, input logic ng, input logic lst);
    aff2d_pkg::term_t r;
    r.asrc = as;
    r.aidx = aff2d_pkg::IDX_BITS'(ai);
    r.bsrc = bs;
    r.bidx = aff2d_pkg::IDX_BITS'(bi);
    r.neg  = ng;
    r.last = lst;
    return r;
  endfunction

  // operand pair for one product of the current job
  always_comb begin
    op = mk(aff2d_pkg::SRC_ACC, 0, aff2d_pkg::SRC_ONE, 0, 1'b0, 1'b1);
    unique case (job)
      aff2d_pkg::WB_ELEM: begin
        priority if (sts.cmd == aff2d_pkg::CMD_SCALE) begin
          op = mk(aff2d_pkg::SRC_ACC, int'(elem), aff2d_pkg::SRC_SCALE, 0, 1'b0, 1'b1);
        end else if (sts.cmd == aff2d_pkg::CMD_ADDSC) begin
          if (term == 2'd0)
            op = mk(aff2d_pkg::SRC_IN, int'(elem), aff2d_pkg::SRC_SCALE, 0, 1'b0, 1'b0);
          else
            op = mk(aff2d_pkg::SRC_ACC, int'(elem), aff2d_pkg::SRC_ONE, 0, 1'b0, 1'b1);
        end else begin
          // compose: column pairs of the operand, translation adds the old one
          if (term == 2'd0)
            op = mk(aff2d_pkg::SRC_ACC, int'(elem[0]), aff2d_pkg::SRC_IN,
                    int'({elem[2:1], 1'b0}), 1'b0, 1'b0);
          else if (term == 2'd1)
            op = mk(aff2d_pkg::SRC_ACC, int'(elem[0]) + 2, aff2d_pkg::SRC_IN,
                    int'({elem[2:1], 1'b1}), 1'b0, elem < 3'd4);
          else
            op = mk(aff2d_pkg::SRC_ACC, int'(elem), aff2d_pkg::SRC_ONE, 0, 1'b0, 1'b1);
        end
      end
      aff2d_pkg::WB_DET:
        op = (term == 2'd0) ? mk(aff2d_pkg::SRC_NEW, 0, aff2d_pkg::SRC_NEW, 3, 1'b0, 1'b0)
                            : mk(aff2d_pkg::SRC_NEW, 1, aff2d_pkg::SRC_NEW, 2, 1'b1, 1'b1);
      aff2d_pkg::WB_IDET:
        op = (term == 2'd0) ? mk(aff2d_pkg::SRC_ACC, 0, aff2d_pkg::SRC_ACC, 3, 1'b0, 1'b0)
                            : mk(aff2d_pkg::SRC_ACC, 1, aff2d_pkg::SRC_ACC, 2, 1'b1, 1'b1);
      aff2d_pkg::WB_T0:
        op = (term == 2'd0) ? mk(aff2d_pkg::SRC_ACC, 2, aff2d_pkg::SRC_ACC, 5, 1'b0, 1'b0)
                            : mk(aff2d_pkg::SRC_ACC, 3, aff2d_pkg::SRC_ACC, 4, 1'b1, 1'b1);
      aff2d_pkg::WB_T1:
        op = (term == 2'd0) ? mk(aff2d_pkg::SRC_ACC, 1, aff2d_pkg::SRC_ACC, 4, 1'b0, 1'b0)
                            : mk(aff2d_pkg::SRC_ACC, 0, aff2d_pkg::SRC_ACC, 5, 1'b1, 1'b1);
      default: op = mk(aff2d_pkg::SRC_ACC, 0, aff2d_pkg::SRC_ONE, 0, 1'b0, 1'b1);
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aff2d_pkg::ST_IDLE;
      job   <= aff2d_pkg::WB_NONE;
      elem  <= '0;
      term  <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      job   <= job_next;
      elem  <= elem_next;
      term  <= term_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    job_next   = job;
    elem_next  = elem;
    term_next  = term;
    cnt_next   = cnt;
    ctl        = '0;
    ctl.elem   = elem;
    ctl.term   = op;
    src_stall  = (state != aff2d_pkg::ST_IDLE);
    dst_valid  = (state == aff2d_pkg::ST_OUT);
    unique case (state)
      aff2d_pkg::ST_IDLE: begin
        if (src_valid) begin
          ctl.latch  = 1'b1;
          state_next = aff2d_pkg::ST_SETUP;
        end
      end
      aff2d_pkg::ST_SETUP: begin
        term_next  = '0;
        elem_next  = '0;
        state_next = aff2d_pkg::ST_MUL;
        priority if (sts.cmd == aff2d_pkg::CMD_SCALE || sts.cmd == aff2d_pkg::CMD_ADDSC ||
                     sts.cmd == aff2d_pkg::CMD_MUL) begin
          job_next = aff2d_pkg::WB_ELEM;
        end else if (sts.cmd == aff2d_pkg::CMD_INV) begin
          job_next = aff2d_pkg::WB_IDET;
        end else begin
          ctl.simple = 1'b1;
          job_next   = aff2d_pkg::WB_DET;
        end
      end
      aff2d_pkg::ST_MUL: begin
        ctl.mul      = 1'b1;
        ctl.acc_init = (term == 2'd0);
        ctl.acc_rnd  = (job == aff2d_pkg::WB_ELEM) || (job == aff2d_pkg::WB_DET);
        state_next   = aff2d_pkg::ST_ACC;
      end
      aff2d_pkg::ST_ACC: begin
        ctl.acc_add = 1'b1;
        if (op.last) begin
          state_next = aff2d_pkg::ST_FIN;
        end else begin
          term_next  = term + 2'd1;
          state_next = aff2d_pkg::ST_MUL;
        end
      end
      aff2d_pkg::ST_FIN: begin
        ctl.wb    = job;
        term_next = '0;
        unique case (job)
          aff2d_pkg::WB_ELEM: begin
            state_next = aff2d_pkg::ST_MUL;
            if (elem == ELEM_LAST) job_next = aff2d_pkg::WB_DET;
            else elem_next = elem + 1'b1;
          end
          aff2d_pkg::WB_IDET: state_next = aff2d_pkg::ST_CHK;
          aff2d_pkg::WB_T0: begin
            job_next   = aff2d_pkg::WB_T1;
            state_next = aff2d_pkg::ST_MUL;
          end
          aff2d_pkg::WB_T1: begin
            elem_next  = '0;
            state_next = aff2d_pkg::ST_DLOAD;
          end
          default: state_next = aff2d_pkg::ST_COMMIT;
        endcase
      end
      aff2d_pkg::ST_CHK: begin
        term_next  = '0;
        state_next = aff2d_pkg::ST_MUL;
        if (sts.sing) begin
          ctl.sing_copy = 1'b1;
          job_next      = aff2d_pkg::WB_DET;
        end else begin
          job_next = aff2d_pkg::WB_T0;
        end
      end
      aff2d_pkg::ST_DLOAD: begin
        ctl.div_load = 1'b1;
        cnt_next     = '0;
        state_next   = aff2d_pkg::ST_DRUN;
      end
      aff2d_pkg::ST_DRUN: begin
        ctl.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_LAST) state_next = aff2d_pkg::ST_DDONE;
      end
      aff2d_pkg::ST_DDONE: begin
        ctl.div_done = 1'b1;
        if (elem == ELEM_LAST) begin
          job_next   = aff2d_pkg::WB_DET;
          term_next  = '0;
          state_next = aff2d_pkg::ST_MUL;
        end else begin
          elem_next  = elem + 1'b1;
          state_next = aff2d_pkg::ST_DLOAD;
        end
      end
      aff2d_pkg::ST_COMMIT: begin
        ctl.commit = 1'b1;
        state_next = aff2d_pkg::ST_OUT;
      end
      aff2d_pkg::ST_OUT: begin
        if (!dst_stall) state_next = aff2d_pkg::ST_IDLE;
      end
      default: state_next = aff2d_pkg::ST_IDLE;
    endcase
  end

  `AFF2D_ASSERT_NXT(a_accept_setup, src_valid && !src_stall, state == aff2d_pkg::ST_SETUP, "accepted word did not start setup")
  `AFF2D_ASSERT_NXT(a_div_len, state == aff2d_pkg::ST_DRUN && cnt == CNT_LAST, state == aff2d_pkg::ST_DDONE, "divider ran past its bit count")
  `AFF2D_ASSERT_IMP(a_term_range, state == aff2d_pkg::ST_ACC, term <= 2'd2 && elem <= ELEM_LAST, "term or element index out of range")
  `AFF2D_ASSERT_IMP(a_out_busy, dst_valid, src_stall, "input open while a result is pending")

endmodule

/* design/aff2d_dpath.sv */
// Datapath of the affine accumulator: matrix registers, shared multiplier, divider.
module aff2d_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  aff2d_pkg::in_word_t               src_word,
  input  logic                              cfg_we,
  input  logic [aff2d_pkg::EPS_BITS-1:0]    cfg_data,
  input  aff2d_pkg::ctl_t                   ctl,
  output aff2d_pkg::sts_t                   sts,
  output aff2d_pkg::out_word_t              dst_word
);

  localparam int W  = aff2d_pkg::WORD_BITS;
  localparam int WW = aff2d_pkg::WIDE_BITS;
  localparam int DW = 2 * W;
  localparam int NW = 4 * W;

  logic signed [W-1:0] acc_m [aff2d_pkg::NUM_ELEM];
  logic signed [W-1:0] new_m [aff2d_pkg::NUM_ELEM];
  logic signed [W-1:0] in_m  [aff2d_pkg::NUM_ELEM];
  aff2d_pkg::in_word_t item;
  logic [aff2d_pkg::EPS_BITS-1:0] eps;
  logic signed [W-1:0] opa, opb, det_q;
  logic signed [DW-1:0] prod;
  logic                 prod_neg;
  logic signed [WW-1:0] sum, sum_sh;
  logic signed [DW:0]   dreg, t0, t1;
  logic                 sing_f, ovf_f;

  logic signed [WW-1:0] rdet, rmag;
  logic signed [DW:0]   num;
  logic [DW-1:0]        nmag, dmag_in, dmag, rem;
  logic [NW-1:0]        nwide;
  logic [W-1:0]         q, nlo;
  logic                 qneg, big;
  logic [DW:0]          trial;
  logic                 ge, up;
  logic [W:0]           qr;
  logic signed [W-1:0]  dres;
  logic                 dovf;

  assign in_m[0] = item.in_e00;
  assign in_m[1] = item.in_e01;
  assign in_m[2] = item.in_e10;
  assign in_m[3] = item.in_e11;
  assign in_m[4] = item.in_e20;
  assign in_m[5] = item.in_e21;

  // operand selection
  always_comb begin
    unique case (ctl.term.asrc)
      aff2d_pkg::SRC_ACC:   opa = acc_m[ctl.term.aidx];
      aff2d_pkg::SRC_NEW:   opa = new_m[ctl.term.aidx];
      aff2d_pkg::SRC_IN:    opa = in_m[ctl.term.aidx];
      aff2d_pkg::SRC_SCALE: opa = item.scale;
      default:              opa = aff2d_pkg::ONE_Q;
    endcase
    unique case (ctl.term.bsrc)
      aff2d_pkg::SRC_ACC:   opb = acc_m[ctl.term.bidx];
      aff2d_pkg::SRC_NEW:   opb = new_m[ctl.term.bidx];
      aff2d_pkg::SRC_IN:    opb = in_m[ctl.term.bidx];
      aff2d_pkg::SRC_SCALE: opb = item.scale;
      default:              opb = aff2d_pkg::ONE_Q;
    endcase
  end

  // multiply then accumulate; each product is registered, then added to or subtracted from the sum
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod     <= opa * opb;
      prod_neg <= ctl.term.neg;
      if (ctl.acc_init) sum <= ctl.acc_rnd ? aff2d_pkg::ROUND_Q : '0;
    end else if (ctl.acc_add) begin
      sum <= prod_neg ? sum - WW'(prod) : sum + WW'(prod);
    end
  end

  assign sum_sh = sum >>> aff2d_pkg::FRAC_BITS;

  // singular test on the rounded determinant
  assign rdet     = ($signed({dreg[DW], dreg}) + aff2d_pkg::ROUND_Q) >>> aff2d_pkg::FRAC_BITS;
  assign rmag     = rdet[WW-1] ? -rdet : rdet;
  assign sts.sing = (dreg == '0) || (rmag < WW'(eps));
  assign sts.cmd  = item.cmd;

  // divider operand: cofactor over determinant
  always_comb begin
    unique case (ctl.elem)
      3'd0:    num = (DW+1)'(acc_m[3]);
      3'd1:    num = -(DW+1)'(acc_m[1]);
      3'd2:    num = -(DW+1)'(acc_m[2]);
      3'd3:    num = (DW+1)'(acc_m[0]);
      3'd4:    num = t0;
      default: num = t1;
    endcase
    nmag    = num[DW] ? DW'(-num) : DW'(num);
    dmag_in = dreg[DW] ? DW'(-dreg) : DW'(dreg);
    if (ctl.elem < 3'd4) nwide = NW'(nmag) << (2 * aff2d_pkg::FRAC_BITS);
    else                 nwide = NW'(nmag) << aff2d_pkg::FRAC_BITS;
    trial = {rem, nlo[W-1]};
    ge    = trial >= {1'b0, dmag};
    up    = {rem, 1'b0} >= {1'b0, dmag};
    qr    = {1'b0, q} + (W+1)'(up);
    dovf  = 1'b0;
    if (qneg) begin
      if (big || qr > (W+1)'(1) << (W - 1)) begin
        dres = aff2d_pkg::WMIN[W-1:0];
        dovf = 1'b1;
      end else begin
        dres = W'(-qr);
      end
    end else begin
      if (big || qr > ((W+1)'(1) << (W - 1)) - 1) begin
        dres = aff2d_pkg::WMAX[W-1:0];
        dovf = 1'b1;
      end else begin
        dres = W'(qr);
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      dmag <= dmag_in;
      rem  <= nwide[W +: DW];
      nlo  <= nwide[W-1:0];
      q    <= '0;
      qneg <= num[DW] ^ dreg[DW];
      big  <= nwide[NW-1:W] >= (NW-W)'(dmag_in);
    end else if (ctl.div_step) begin
      rem <= ge ? DW'(trial - {1'b0, dmag}) : trial[DW-1:0];
      nlo <= nlo << 1;
      q   <= {q[W-2:0], ge};
    end
  end

  // item, flags and new matrix
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item   <= src_word;
      sing_f <= 1'b0;
      ovf_f  <= 1'b0;
    end
    if (ctl.simple) begin
      for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++) begin
        unique case (item.cmd)
          aff2d_pkg::CMD_LOAD:  new_m[i] <= in_m[i];
          aff2d_pkg::CMD_IDENT: new_m[i] <= (i == 0 || i == 3) ? aff2d_pkg::ONE_Q : '0;
          aff2d_pkg::CMD_ZERO:  new_m[i] <= '0;
          aff2d_pkg::CMD_ADD:   new_m[i] <= aff2d_pkg::sat_word(WW'(acc_m[i]) + WW'(in_m[i]));
          aff2d_pkg::CMD_SUB:   new_m[i] <= aff2d_pkg::sat_word(WW'(acc_m[i]) - WW'(in_m[i]));
          default:              new_m[i] <= acc_m[i];
        endcase
      end
      if (item.cmd == aff2d_pkg::CMD_ADD || item.cmd == aff2d_pkg::CMD_SUB) begin
        for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++) begin
          if (aff2d_pkg::ovf_word(item.cmd == aff2d_pkg::CMD_ADD ?
                                  WW'(acc_m[i]) + WW'(in_m[i]) :
                                  WW'(acc_m[i]) - WW'(in_m[i])))
            ovf_f <= 1'b1;
        end
      end
    end
    if (ctl.sing_copy) begin
      sing_f <= 1'b1;
      for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++) new_m[i] <= acc_m[i];
    end
    unique case (ctl.wb)
      aff2d_pkg::WB_ELEM: begin
        new_m[ctl.elem] <= aff2d_pkg::sat_word(sum_sh);
        if (aff2d_pkg::ovf_word(sum_sh)) ovf_f <= 1'b1;
      end
      aff2d_pkg::WB_DET:  det_q <= aff2d_pkg::sat_word(sum_sh);
      aff2d_pkg::WB_IDET: dreg  <= sum[DW:0];
      aff2d_pkg::WB_T0:   t0    <= sum[DW:0];
      aff2d_pkg::WB_T1:   t1    <= sum[DW:0];
      default: ;
    endcase
    if (ctl.div_done) begin
      new_m[ctl.elem] <= dres;
      if (dovf) ovf_f <= 1'b1;
    end
  end

  // accumulator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++)
        acc_m[i] <= (i == 0 || i == 3) ? aff2d_pkg::ONE_Q : '0;
    end else if (ctl.commit) begin
      for (int i = 0; i < aff2d_pkg::NUM_ELEM; i++) acc_m[i] <= new_m[i];
    end
    if (ctl.commit) begin
      dst_word.res_e00     <= new_m[0];
      dst_word.res_e01     <= new_m[1];
      dst_word.res_e10     <= new_m[2];
      dst_word.res_e11     <= new_m[3];
      dst_word.res_e20     <= new_m[4];
      dst_word.res_e21     <= new_m[5];
      dst_word.determinant <= det_q;
      dst_word.singular    <= sing_f;
      dst_word.overflow    <= ovf_f;
    end
  end

  // epsilon register
  always_ff @(posedge clk) begin
    if (rst) eps <= aff2d_pkg::EPS_RESET;
    else if (cfg_we) eps <= cfg_data;
  end

endmodule

/* design/affine2d_matrix_accumulator.sv */
// Top level of the 2D affine matrix accumulator (Q16.16).
//
// src channel: one command word (cmd, operand matrix, scale) per handshake,
//   taken when src_valid is high and src_stall is low.
// dst channel: one result word per command (new matrix, its determinant,
//   singular and overflow flags), taken when dst_valid is high and
//   dst_stall is low.
// cfg channel: writes the epsilon threshold; cfg_ready is always high.
// One command is processed at a time; src_stall stays high from accept
// until the result has been taken. The next command can be taken in the
// cycle after the result is taken. An invert runs the bit-serial divider
// once for each of the six elements; a singular invert keeps the old
// matrix and sets the singular flag.
// All products go through one shared 32x32 multiplier.
// A stalled result holds in the output register until taken.
// Synchronous reset loads the identity matrix and an epsilon of 7.
module affine2d_matrix_accumulator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           src_valid,
  output logic                           src_stall,
  input  aff2d_pkg::in_word_t            src_word,
  output logic                           dst_valid,
  input  logic                           dst_stall,
  output aff2d_pkg::out_word_t           dst_word,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aff2d_pkg::EPS_BITS-1:0] cfg_data
);

  aff2d_pkg::ctl_t ctl;
  aff2d_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  aff2d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  aff2d_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .src_word (src_word),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .ctl      (ctl),
    .sts      (sts),
    .dst_word (dst_word)
  );

endmodule

/* sim/affine2d_matrix_accumulator_test.sv */
// Testbench of the 2D affine matrix accumulator: self-checking, random and directed commands.
`timescale 1ns / 1ps
module affine2d_matrix_accumulator_test;

  localparam int W = aff2d_pkg::WORD_BITS;
  localparam int F = aff2d_pkg::FRAC_BITS;
  localparam longint QCAP = longint'(1) << 40;
  localparam longint ONE = longint'(1) << F;
  localparam int TIMEOUT = 2000000;
  // codes with no command behind them
  localparam logic [3:0] CMD_SPARE_LO = 4'd9;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  logic clk = 0;
  logic rst = 1;
  logic src_valid = 0;
  logic src_stall;
  aff2d_pkg::in_word_t src_word = '0;
  logic dst_valid;
  logic dst_stall = 0;
  aff2d_pkg::out_word_t dst_word;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [aff2d_pkg::EPS_BITS-1:0] cfg_data = '0;

  affine2d_matrix_accumulator uut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_stall(src_stall), .src_word(src_word),
    .dst_valid(dst_valid), .dst_stall(dst_stall), .dst_word(dst_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  longint acc_m[6];
  longint eps_q;
  aff2d_pkg::out_word_t results_due[$];
  int errors = 0;
  int cycles = 0;
  int src_idle_pct = 0;
  int dst_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint sat_q(input longint v, inout bit ovf);
    longint mx;
    longint mn;
    mx = (longint'(1) << (W - 1)) - 1;
    mn = -mx - 1;
    if (v > mx) begin
      ovf = 1;
      return mx;
    end
    if (v < mn) begin
      ovf = 1;
      return mn;
    end
    return v;
  endfunction

  // round of sum/2^F, half up; each product is split at bit F so the sum does not overflow 64 bits
  function automatic longint round_sum(input longint p0, input longint p1, input longint p2);
    longint hi;
    longint lo;
    hi = (p0 >>> F) + (p1 >>> F) + (p2 >>> F);
    lo = (p0 & (ONE - 1)) + (p1 & (ONE - 1)) + (p2 & (ONE - 1)) + (ONE >> 1);
    return hi + (lo >>> F);
  endfunction

  function automatic longint div_round(input longint num, input longint den, input int k,
                                       inout bit ovf);
    longint unsigned n;
    longint unsigned d;
    longint unsigned q;
    longint unsigned r;
    longint s;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    q = n / d;
    r = n % d;
    if (q > QCAP) q = QCAP;
    for (int i = 0; i < k; i++) begin
      q = q << 1;
      r = r << 1;
      if (r >= d) begin
        r -= d;
        q++;
      end
      if (q > QCAP) q = QCAP;
    end
    if (r >= d - r) q++;
    s = longint'(q);
    if ((num < 0) != (den < 0)) s = -s;
    return sat_q(s, ovf);
  endfunction

  // expected result of one command; updates the accumulator copy
  function automatic aff2d_pkg::out_word_t predict_matrix(input aff2d_pkg::in_word_t w);
    longint a[6];
    longint b[6];
    longint nm[6];
    longint s;
    longint d;
    longint rd;
    bit ovf;
    bit sng;
    bit dummy;
    aff2d_pkg::out_word_t o;
    ovf = 0;
    sng = 0;
    b[0] = longint'(w.in_e00); b[1] = longint'(w.in_e01); b[2] = longint'(w.in_e10);
    b[3] = longint'(w.in_e11); b[4] = longint'(w.in_e20); b[5] = longint'(w.in_e21);
    s = longint'(w.scale);
    for (int i = 0; i < 6; i++) begin
      a[i] = acc_m[i];
      nm[i] = a[i];
    end
    case (w.cmd)
      aff2d_pkg::CMD_LOAD: for (int i = 0; i < 6; i++) nm[i] = b[i];
      aff2d_pkg::CMD_IDENT: begin
        for (int i = 0; i < 6; i++) nm[i] = 0;
        nm[0] = ONE;
        nm[3] = ONE;
      end
      aff2d_pkg::CMD_ZERO: for (int i = 0; i < 6; i++) nm[i] = 0;
      aff2d_pkg::CMD_ADD: for (int i = 0; i < 6; i++) nm[i] = sat_q(a[i] + b[i], ovf);
      aff2d_pkg::CMD_SUB: for (int i = 0; i < 6; i++) nm[i] = sat_q(a[i] - b[i], ovf);
      aff2d_pkg::CMD_SCALE: for (int i = 0; i < 6; i++)
        nm[i] = sat_q(round_sum(a[i] * s, 0, 0), ovf);
      aff2d_pkg::CMD_ADDSC: for (int i = 0; i < 6; i++)
        nm[i] = sat_q(round_sum(b[i] * s, a[i] * ONE, 0), ovf);
      aff2d_pkg::CMD_MUL: begin
        nm[0] = sat_q(round_sum(a[0] * b[0], a[2] * b[1], 0), ovf);
        nm[1] = sat_q(round_sum(a[1] * b[0], a[3] * b[1], 0), ovf);
        nm[2] = sat_q(round_sum(a[0] * b[2], a[2] * b[3], 0), ovf);
        nm[3] = sat_q(round_sum(a[1] * b[2], a[3] * b[3], 0), ovf);
        nm[4] = sat_q(round_sum(a[0] * b[4], a[2] * b[5], a[4] * ONE), ovf);
        nm[5] = sat_q(round_sum(a[1] * b[4], a[3] * b[5], a[5] * ONE), ovf);
      end
      aff2d_pkg::CMD_INV: begin
        d = a[0] * a[3] - a[1] * a[2];
        rd = round_sum(a[0] * a[3], -(a[1] * a[2]), 0);
        if (rd < 0) rd = -rd;
        if (d == 0 || rd < eps_q) sng = 1;
        else begin
          nm[0] = div_round(a[3], d, 2 * F, ovf);
          nm[1] = div_round(-a[1], d, 2 * F, ovf);
          nm[2] = div_round(-a[2], d, 2 * F, ovf);
          nm[3] = div_round(a[0], d, 2 * F, ovf);
          nm[4] = div_round(a[2] * a[5] - a[3] * a[4], d, F, ovf);
          nm[5] = div_round(a[1] * a[4] - a[0] * a[5], d, F, ovf);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 6; i++) acc_m[i] = nm[i];
    o.res_e00 = W'(nm[0]); o.res_e01 = W'(nm[1]); o.res_e10 = W'(nm[2]);
    o.res_e11 = W'(nm[3]); o.res_e20 = W'(nm[4]); o.res_e21 = W'(nm[5]);
    dummy = 0;
    o.determinant = W'(sat_q(round_sum(nm[0] * nm[3], -(nm[1] * nm[2]), 0), dummy));
    o.singular = sng;
    o.overflow = ovf;
    return o;
  endfunction

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      dst_stall <= 1;
    end else begin
      dst_stall <= ($urandom_range(99) < dst_stall_pct);
    end
  end

  // check each accepted result word
  always @(posedge clk) begin
    aff2d_pkg::out_word_t e;
    if (!rst && dst_valid && !dst_stall) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = results_due.pop_front();
        if (dst_word.res_e00 !== e.res_e00) begin
          $error("res_e00 exp %0d got %0d", e.res_e00, dst_word.res_e00); errors++;
        end
        if (dst_word.res_e01 !== e.res_e01) begin
          $error("res_e01 exp %0d got %0d", e.res_e01, dst_word.res_e01); errors++;
        end
        if (dst_word.res_e10 !== e.res_e10) begin
          $error("res_e10 exp %0d got %0d", e.res_e10, dst_word.res_e10); errors++;
        end
        if (dst_word.res_e11 !== e.res_e11) begin
          $error("res_e11 exp %0d got %0d", e.res_e11, dst_word.res_e11); errors++;
        end
        if (dst_word.res_e20 !== e.res_e20) begin
          $error("res_e20 exp %0d got %0d", e.res_e20, dst_word.res_e20); errors++;
        end
        if (dst_word.res_e21 !== e.res_e21) begin
          $error("res_e21 exp %0d got %0d", e.res_e21, dst_word.res_e21); errors++;
        end
        if (dst_word.determinant !== e.determinant) begin
          $error("determinant exp %0d got %0d", e.determinant, dst_word.determinant);
          errors++;
        end
        if (dst_word.singular !== e.singular) begin
          $error("singular exp %0b got %0b", e.singular, dst_word.singular); errors++;
        end
        if (dst_word.overflow !== e.overflow) begin
          $error("overflow exp %0b got %0b", e.overflow, dst_word.overflow); errors++;
        end
      end
    end
  end

  // offer one command word and hold it until accepted; valid stays up for the next one
  task automatic send_cmd(input aff2d_pkg::in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 0;
      @(posedge clk);
    end
    src_valid <= 1;
    src_word <= w;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    results_due.push_back(predict_matrix(w));
  endtask

  task automatic wait_drained();
    src_valid <= 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_eps(input logic [aff2d_pkg::EPS_BITS-1:0] v);
    wait_drained();
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    eps_q = longint'(v);
  endtask

  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
      default: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
    endcase
  endfunction

  function automatic aff2d_pkg::in_word_t make_cmd(input logic [3:0] c);
    aff2d_pkg::in_word_t w;
    w.cmd = c;
    w.in_e00 = rand_elem(); w.in_e01 = rand_elem(); w.in_e10 = rand_elem();
    w.in_e11 = rand_elem(); w.in_e20 = rand_elem(); w.in_e21 = rand_elem();
    w.scale = rand_elem();
    return w;
  endfunction

  function automatic aff2d_pkg::in_word_t load_cmd(input longint e00, input longint e01,
                                                   input longint e10, input longint e11);
    aff2d_pkg::in_word_t w;
    w = make_cmd(aff2d_pkg::CMD_LOAD);
    w.in_e00 = W'(e00); w.in_e01 = W'(e01); w.in_e10 = W'(e10); w.in_e11 = W'(e11);
    return w;
  endfunction

  function automatic longint rand_small();
    return longint'($signed($urandom_range(262144))) - longint'(131072);
  endfunction

  // extremes, every command, singular and unused codes
  task automatic test_directed();
    aff2d_pkg::in_word_t w;
    w = '0; w.cmd = aff2d_pkg::CMD_LOAD;
    w.in_e00 = 32'sh7fff_ffff; w.in_e01 = 32'sh8000_0000; w.in_e10 = -1;
    w.in_e11 = 32'sh7fff_ffff; w.in_e20 = 32'sh8000_0000; w.in_e21 = 1;
    w.scale = 32'sh7fff_ffff;
    send_cmd(w);
    w.cmd = aff2d_pkg::CMD_ADD; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_SUB; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_SCALE; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_ADDSC; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_MUL; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_INV; send_cmd(w);
    w = '1; w.cmd = aff2d_pkg::CMD_IDENT; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_INV; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_ZERO; send_cmd(w);
    w.cmd = aff2d_pkg::CMD_INV; send_cmd(w);          // exact zero determinant
    w.cmd = CMD_SPARE_LO; send_cmd(w);
    w.cmd = CMD_SPARE_HI; send_cmd(w);
    send_cmd(load_cmd(2, 0, 0, 2));                    // tiny determinant that rounds to zero
    send_cmd(make_cmd(aff2d_pkg::CMD_INV));
    send_cmd(load_cmd(1, 0, 0, 1));
    send_cmd(make_cmd(aff2d_pkg::CMD_INV));
    send_cmd(load_cmd(2 * ONE, ONE, 3 * ONE, -ONE));
    send_cmd(make_cmd(aff2d_pkg::CMD_INV));
    w = make_cmd(aff2d_pkg::CMD_SCALE); w.scale = 32'sh8000_0000; send_cmd(w);
  endtask

  // random command mix, mostly a build-up of a sane matrix then operations on it
  task automatic test_random(input int n);
    logic [3:0] c;
    aff2d_pkg::in_word_t w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: c = aff2d_pkg::CMD_INV;
        2: c = aff2d_pkg::CMD_MUL;
        3: c = aff2d_pkg::CMD_ADDSC;
        4: c = aff2d_pkg::CMD_SCALE;
        5: c = 4'($urandom_range(aff2d_pkg::CMD_INV, aff2d_pkg::CMD_ADD));
        6: c = 4'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
        default: c = 4'($urandom_range(aff2d_pkg::CMD_ZERO));
      endcase
      w = make_cmd(c);
      if (c == aff2d_pkg::CMD_LOAD && $urandom_range(1))
        w = load_cmd(rand_small(), rand_small(), rand_small(), rand_small());
      send_cmd(w);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    test_random(10);
  endtask

  initial begin
    ref_init();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    write_eps(17'd0);
    test_directed();
    write_eps(17'd65536);
    test_directed();
    write_eps(17'd1000);
    src_idle_pct = 0; dst_stall_pct = 0; test_random(450);
    write_eps(17'd7);
    src_idle_pct = 79; dst_stall_pct = 0; test_random(400);
    test_backpressure();
    write_eps(17'd0);
    src_idle_pct = 0; dst_stall_pct = 79; test_random(400);
    write_eps(17'd65536);
    src_idle_pct = 17; dst_stall_pct = 17; test_random(630);
    wait_drained();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  task automatic ref_init();
    for (int i = 0; i < 6; i++) acc_m[i] = 0;
    acc_m[0] = ONE;
    acc_m[3] = ONE;
    eps_q = 7;
  endtask

endmodule
